[src/lec_pkg.sv]
// lec_pkg: shared types and constants for the utf16 line ending converter
// used by lec_xlate and utf16_line_ending_converter; no dependencies
package lec_pkg;

  localparam logic [15:0] CH_LF   = 16'h000A;
  localparam logic [15:0] CH_CR   = 16'h000D;
  localparam logic [15:0] MARK_LE = 16'hFEFF;
  localparam logic [15:0] MARK_BE = 16'hFFFE;
  localparam logic [15:0] CH_NUL  = 16'h0000;

  // conversion modes; code 3 acts as MODE_LF_CRLF
  localparam logic [1:0] MODE_LF_CRLF = 2'd0;
  localparam logic [1:0] MODE_CRLF_LF = 2'd1;
  localparam logic [1:0] MODE_LATIN1  = 2'd2;
  localparam logic [1:0] MODE_ALIAS   = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_BE_MARK  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_MODE     = 2'd0;
  localparam logic [1:0] REG_EXPAND   = 2'd1;
  localparam logic [1:0] REG_CAPACITY = 2'd2;

  localparam int CFG_W       = 17;
  localparam int GRP_DEPTH   = 4;
  localparam logic [16:0] CAPACITY_RESET = 17'h10000;

  typedef struct packed {
    logic [15:0] in_unit;
    logic        src_last;
  } in_item_t;

  typedef struct packed {
    logic [15:0] out_unit;
    logic        out_last;
    logic [1:0]  status;
  } out_item_t;

  // string state flags
  typedef struct packed {
    logic held_cr;
    logic at_start;
    logic skipping;
  } str_flags_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       expand;
  } cvt_cfg_t;

  // results caused by one input transaction
  typedef struct packed {
    out_item_t [GRP_DEPTH-1:0] entry;
    logic [2:0]                cnt;
  } res_grp_t;

endpackage

[src/utf16_line_ending_converter.sv]
// utf16_line_ending_converter: top level with config registers, string state,
// result group buffer and output register; uses lec_pkg and lec_xlate
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------
//  input   | in_valid / in_stall   | in_item  (in_unit, src_last)
//  output  | out_valid / out_stall | out_item (out_unit, out_last, status)
//  config  | cfg_we                | cfg_index, cfg_data
//
// an input transaction is translated combinationally into a group of 0 to 4
// result units; the group drains through the output register at one unit a
// cycle while the output is not stalled
// the next item is taken in the cycle the last unit of the group moves out
// reset is synchronous; no clearing pass
module utf16_line_ending_converter #(
  parameter int MAX_OUTPUT_UNITS = 65536
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  lec_pkg::in_item_t          in_item,
  output logic                       out_valid,
  input  logic                       out_stall,
  output lec_pkg::out_item_t         out_item,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [lec_pkg::CFG_W-1:0]  cfg_data
);

  localparam int PW = $clog2(MAX_OUTPUT_UNITS + 1);
  localparam int CW = (PW > lec_pkg::CFG_W) ? PW : lec_pkg::CFG_W;

  logic [1:0]          mode;
  logic                expand;
  logic [16:0]         capacity;
  lec_pkg::str_flags_t flags;
  lec_pkg::str_flags_t flags_next;
  logic [PW-1:0]       pos;
  logic [PW-1:0]       pos_next;
  logic [PW-1:0]       cap_now;
  lec_pkg::res_grp_t   grp;
  lec_pkg::res_grp_t   grp_new;
  logic                out_load;
  logic                in_fire;

  // effective capacity is the smaller of the register and the hard limit
  assign cap_now = (CW'(capacity) > CW'(MAX_OUTPUT_UNITS)) ? PW'(MAX_OUTPUT_UNITS)
                                                          : PW'(capacity);

  lec_xlate #(.PW(PW)) u_xlate (
    .item       (in_item),
    .flags      (flags),
    .pos        (pos),
    .cfg        ({mode, expand}),
    .cap_now    (cap_now),
    .grp        (grp_new),
    .flags_next (flags_next),
    .pos_next   (pos_next)
  );

  assign out_load = (grp.cnt != 3'd0) && (!out_valid || !out_stall);
  assign in_stall = !((grp.cnt == 3'd0) || (grp.cnt == 3'd1 && out_load));
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= lec_pkg::MODE_LF_CRLF;
      expand   <= 1'b0;
      capacity <= lec_pkg::CAPACITY_RESET;
      flags    <= '{held_cr: 1'b0, at_start: 1'b1, skipping: 1'b0};
      pos      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          lec_pkg::REG_MODE:     mode <= cfg_data[1:0];
          lec_pkg::REG_EXPAND:   expand <= cfg_data[0];
          lec_pkg::REG_CAPACITY: capacity <= cfg_data;
          default: ;
        endcase
      end
      // a mode write restarts the string
      if (cfg_we && cfg_index == lec_pkg::REG_MODE) begin
        flags <= '{held_cr: 1'b0, at_start: 1'b1, skipping: 1'b0};
        pos   <= '0;
      end else if (in_fire) begin
        flags <= flags_next;
        pos   <= (flags_next.at_start) ? '0 : pos_next;
      end
    end
  end

  // result group buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      grp.cnt <= 3'd0;
    end else if (in_fire) begin
      grp.cnt <= grp_new.cnt;
    end else if (out_load) begin
      grp.cnt <= grp.cnt - 3'd1;
    end
    if (in_fire) begin
      grp.entry <= grp_new.entry;
    end else if (out_load) begin
      for (int k = 0; k < lec_pkg::GRP_DEPTH - 1; k++) begin
        grp.entry[k] <= grp.entry[k+1];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item <= grp.entry[0];
    end
  end

  a_grp_depth: assert property (@(posedge clk) disable iff (rst)
    grp.cnt <= 3'(lec_pkg::GRP_DEPTH))
    else $error("result group count beyond depth");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status != lec_pkg::ST_OK |-> out_item.out_last)
    else $error("error status without end of string");

  a_skip_silent: assert property (@(posedge clk) disable iff (rst)
    in_fire && flags.skipping |=> grp.cnt == 3'd0)
    else $error("skipped transaction produced results");

endmodule

[src/lec_xlate.sv]
// lec_xlate: translates one source unit into its group of result units,
// applies the capacity check and computes the next string state; uses lec_pkg
module lec_xlate #(
  parameter int PW = 17
) (
  input  lec_pkg::in_item_t   item,
  input  lec_pkg::str_flags_t flags,
  input  logic [PW-1:0]       pos,
  input  lec_pkg::cvt_cfg_t   cfg,
  input  logic [PW-1:0]       cap_now,
  output lec_pkg::res_grp_t   grp,
  output lec_pkg::str_flags_t flags_next,
  output logic [PW-1:0]       pos_next
);

  localparam int DW = (PW > 3) ? PW : 3;

  logic [1:0]  mode;
  logic [15:0] unit;
  logic        term;
  logic        is_be;
  logic [3:0][15:0] cu;
  logic [3:0]  cl;
  logic [2:0]  n;
  logic        held_new;
  logic [DW-1:0] diff;
  logic [2:0]  room;
  logic [2:0]  ok_cnt;
  logic        failed;

  assign mode  = (cfg.mode == lec_pkg::MODE_ALIAS) ? lec_pkg::MODE_LF_CRLF : cfg.mode;
  assign unit  = (mode == lec_pkg::MODE_LATIN1) ? {8'h00, item.in_unit[7:0]} : item.in_unit;
  assign term  = (unit == lec_pkg::CH_NUL);
  assign is_be = flags.at_start && (mode != lec_pkg::MODE_LATIN1) && (unit == lec_pkg::MARK_BE);

  // candidate units before the capacity check
  always_comb begin
    cu = '0;
    cl = '0;
    n = 3'd0;
    held_new = flags.held_cr;
    if (flags.at_start && mode == lec_pkg::MODE_CRLF_LF && unit != lec_pkg::MARK_LE) begin
      cu[n[1:0]] = lec_pkg::MARK_LE;
      n = n + 3'd1;
    end
    if (!term) begin
      case (mode)
        lec_pkg::MODE_CRLF_LF: begin
          if (flags.held_cr) begin
            if (unit == lec_pkg::CH_LF) begin
              cu[n[1:0]] = lec_pkg::CH_LF;
              n = n + 3'd1;
              held_new = 1'b0;
            end else begin
              cu[n[1:0]] = lec_pkg::CH_CR;
              n = n + 3'd1;
              if (unit == lec_pkg::CH_CR) begin
                held_new = 1'b1;
              end else begin
                cu[n[1:0]] = unit;
                n = n + 3'd1;
                held_new = 1'b0;
              end
            end
          end else if (unit == lec_pkg::CH_CR) begin
            held_new = 1'b1;
          end else begin
            cu[n[1:0]] = unit;
            n = n + 3'd1;
          end
        end
        lec_pkg::MODE_LATIN1: begin
          if (unit == lec_pkg::CH_LF) begin
            cu[n[1:0]] = lec_pkg::CH_CR;
            n = n + 3'd1;
          end
          cu[n[1:0]] = unit;
          n = n + 3'd1;
          held_new = 1'b0;
        end
        default: begin
          if (flags.held_cr && cfg.expand && unit != lec_pkg::CH_LF) begin
            cu[n[1:0]] = lec_pkg::CH_LF;
            n = n + 3'd1;
          end
          if (flags.at_start && unit == lec_pkg::MARK_LE) begin
            // leading LE mark dropped
          end else if (unit == lec_pkg::CH_LF && !flags.held_cr) begin
            cu[n[1:0]] = lec_pkg::CH_CR;
            cu[n[1:0] + 2'd1] = lec_pkg::CH_LF;
            n = n + 3'd2;
          end else begin
            cu[n[1:0]] = unit;
            n = n + 3'd1;
          end
          held_new = (unit == lec_pkg::CH_CR);
        end
      endcase
    end
    if (term || item.src_last) begin
      if (held_new) begin
        if (mode == lec_pkg::MODE_LF_CRLF && cfg.expand) begin
          cu[n[1:0]] = lec_pkg::CH_LF;
          n = n + 3'd1;
        end else if (mode == lec_pkg::MODE_CRLF_LF) begin
          cu[n[1:0]] = lec_pkg::CH_CR;
          n = n + 3'd1;
        end
      end
      cu[n[1:0]] = lec_pkg::CH_NUL;
      cl[n[1:0]] = 1'b1;
      n = n + 3'd1;
    end
  end

  // room left in the destination, saturated at the group depth
  assign diff = DW'(cap_now) - DW'(pos);
  always_comb begin
    if (pos >= cap_now) begin
      room = 3'd0;
    end else if (diff >= DW'(lec_pkg::GRP_DEPTH)) begin
      room = 3'(lec_pkg::GRP_DEPTH);
    end else begin
      room = diff[2:0];
    end
  end
  assign failed = (n > room);
  assign ok_cnt = failed ? room : n;
  assign pos_next = PW'(DW'(pos) + DW'(ok_cnt));

  always_comb begin
    grp = '0;
    for (int k = 0; k < lec_pkg::GRP_DEPTH; k++) begin
      if (3'(k) < ok_cnt) begin
        grp.entry[k] = '{out_unit: cu[k], out_last: cl[k], status: lec_pkg::ST_OK};
      end else begin
        grp.entry[k] = '{out_unit: lec_pkg::CH_NUL, out_last: 1'b1,
                         status: lec_pkg::ST_OVERFLOW};
      end
    end
    if (is_be) begin
      grp.entry[0] = '{out_unit: lec_pkg::CH_NUL, out_last: 1'b1,
                       status: lec_pkg::ST_BE_MARK};
    end
    if (flags.skipping) begin
      grp.cnt = 3'd0;
    end else if (is_be) begin
      grp.cnt = 3'd1;
    end else begin
      grp.cnt = failed ? ok_cnt + 3'd1 : ok_cnt;
    end
  end

  // string state after this transaction
  always_comb begin
    if (flags.skipping) begin
      flags_next = flags;
      if (item.src_last) begin
        flags_next = '{held_cr: 1'b0, at_start: 1'b1, skipping: 1'b0};
      end
    end else if (is_be) begin
      flags_next = '{held_cr: flags.held_cr, at_start: 1'b0, skipping: 1'b1};
      if (item.src_last) begin
        flags_next = '{held_cr: 1'b0, at_start: 1'b1, skipping: 1'b0};
      end
    end else if (term || item.src_last) begin
      flags_next = '{held_cr: 1'b0, at_start: 1'b1, skipping: term && !item.src_last};
    end else begin
      flags_next = '{held_cr: held_new, at_start: 1'b0, skipping: failed};
    end
  end

endmodule

[dv/utf16_line_ending_converter_tb.sv]
// utf16_line_ending_converter_tb: self-checking testbench for the line ending converter
// a scoreboard class predicts every result unit; it depends on lec_pkg and the top level
module utf16_line_ending_converter_tb;

  localparam int MAX_UNITS      = 65536;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int HOLD_CYCLES    = 150;
  localparam int SETTLE_CYCLES  = 8;

  class line_end_scoreboard;
    logic [1:0]  mode;
    logic        expand;
    logic [16:0] capacity;
    logic        cr_pending;
    logic        at_start;
    logic        skipping;
    int          out_pos;
    int          cap_now;
    int          group_cnt;
    bit          failed;
    lec_pkg::out_item_t queued_units[$];
    int          errors;
    int          units_taken;
    int          results_seen;

    function new();
      mode     = lec_pkg::MODE_LF_CRLF;
      expand   = 1'b0;
      capacity = lec_pkg::CAPACITY_RESET;
      restart_string();
    endfunction

    function void restart_string();
      cr_pending = 1'b0;
      out_pos    = 0;
      at_start   = 1'b1;
      skipping   = 1'b0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [16:0] val);
      case (idx)
        lec_pkg::REG_MODE: begin
          mode = val[1:0];
          restart_string();
        end
        lec_pkg::REG_EXPAND:   expand = val[0];
        lec_pkg::REG_CAPACITY: capacity = val;
        default: ;
      endcase
    endfunction

    function void emit(logic [15:0] u, logic l, logic [1:0] st);
      lec_pkg::out_item_t r;
      if (group_cnt >= lec_pkg::GRP_DEPTH) return;
      r.out_unit = u;
      r.out_last = l;
      r.status   = st;
      queued_units.push_back(r);
      group_cnt++;
    endfunction

    // every unit, terminator included, must fit below the capacity
    function void put_unit(logic [15:0] u, logic l);
      if (failed) return;
      if (out_pos >= cap_now) begin
        emit(lec_pkg::CH_NUL, 1'b1, lec_pkg::ST_OVERFLOW);
        failed = 1'b1;
        return;
      end
      emit(u, l, lec_pkg::ST_OK);
      out_pos++;
    endfunction

    function void take_unit(lec_pkg::in_item_t it);
      logic [15:0] u;
      logic        lst;
      logic        first_unit;
      logic        ends_here;
      logic [1:0]  m;
      u   = it.in_unit;
      lst = it.src_last;
      m   = (mode == lec_pkg::MODE_ALIAS) ? lec_pkg::MODE_LF_CRLF : mode;
      units_taken++;
      group_cnt = 0;
      failed    = 1'b0;
      cap_now   = (int'(capacity) > MAX_UNITS) ? MAX_UNITS : int'(capacity);
      if (skipping) begin
        if (lst) restart_string();
        return;
      end
      if (m == lec_pkg::MODE_LATIN1) u = {8'h00, u[7:0]};
      first_unit = at_start;
      at_start   = 1'b0;

      if (first_unit && m != lec_pkg::MODE_LATIN1 && u == lec_pkg::MARK_BE) begin
        emit(lec_pkg::CH_NUL, 1'b1, lec_pkg::ST_BE_MARK);
        if (lst) restart_string();
        else skipping = 1'b1;
        return;
      end
      if (first_unit && m == lec_pkg::MODE_CRLF_LF && u != lec_pkg::MARK_LE) begin
        put_unit(lec_pkg::MARK_LE, 1'b0);
      end

      ends_here = (u == lec_pkg::CH_NUL);
      if (!ends_here) begin
        if (m == lec_pkg::MODE_LF_CRLF) begin
          if (cr_pending && expand && u != lec_pkg::CH_LF) put_unit(lec_pkg::CH_LF, 1'b0);
          // a leading LE mark is dropped
          if (!(first_unit && u == lec_pkg::MARK_LE)) begin
            if (u == lec_pkg::CH_LF && !cr_pending) begin
              put_unit(lec_pkg::CH_CR, 1'b0);
              put_unit(lec_pkg::CH_LF, 1'b0);
            end else begin
              put_unit(u, 1'b0);
            end
          end
          cr_pending = (u == lec_pkg::CH_CR);
        end else if (m == lec_pkg::MODE_CRLF_LF) begin
          if (cr_pending) begin
            if (u == lec_pkg::CH_LF) begin
              put_unit(lec_pkg::CH_LF, 1'b0);
              cr_pending = 1'b0;
            end else begin
              put_unit(lec_pkg::CH_CR, 1'b0);
              if (u != lec_pkg::CH_CR) begin
                put_unit(u, 1'b0);
                cr_pending = 1'b0;
              end
            end
          end else if (u == lec_pkg::CH_CR) begin
            cr_pending = 1'b1;
          end else begin
            put_unit(u, 1'b0);
          end
        end else begin
          if (u == lec_pkg::CH_LF) begin
            put_unit(lec_pkg::CH_CR, 1'b0);
            put_unit(lec_pkg::CH_LF, 1'b0);
          end else begin
            put_unit(u, 1'b0);
          end
          cr_pending = 1'b0;
        end
      end

      if (ends_here || lst) begin
        if (cr_pending) begin
          if (m == lec_pkg::MODE_LF_CRLF && expand) put_unit(lec_pkg::CH_LF, 1'b0);
          else if (m == lec_pkg::MODE_CRLF_LF) put_unit(lec_pkg::CH_CR, 1'b0);
        end
        put_unit(lec_pkg::CH_NUL, 1'b1);
        restart_string();
        // a zero unit before the marked end discards the rest of the source
        if (!lst) skipping = 1'b1;
      end else if (failed) begin
        skipping = 1'b1;
      end
    endfunction

    function void check_unit(lec_pkg::out_item_t got);
      lec_pkg::out_item_t want;
      results_seen++;
      if (queued_units.size() == 0) begin
        $display("%0t: unexpected result: unit %h last %b status %0d",
                 $time, got.out_unit, got.out_last, got.status);
        errors++;
        return;
      end
      want = queued_units.pop_front();
      if (got.out_unit !== want.out_unit) begin
        $display("%0t: out_unit mismatch: expected %h actual %h",
                 $time, want.out_unit, got.out_unit);
        errors++;
      end
      if (got.out_last !== want.out_last) begin
        $display("%0t: out_last mismatch: expected %b actual %b",
                 $time, want.out_last, got.out_last);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status mismatch: expected %0d actual %0d",
                 $time, want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  lec_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  logic               out_stall = 1'b1;
  lec_pkg::out_item_t out_item;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = lec_pkg::REG_MODE;
  logic [16:0]        cfg_data = '0;

  line_end_scoreboard sb = new();
  int gap_style = 1;
  int hold_req = 0;
  int idle_cycles = 0;
  int configs_run = 0;

  always #1 clk = ~clk;

  utf16_line_ending_converter #(
    .MAX_OUTPUT_UNITS(MAX_UNITS)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // transaction monitor: predict on input, check on output
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.take_unit(in_item);
      if (out_valid && !out_stall) sb.check_unit(out_item);
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: timeout, no transaction for %0d cycles", $time, idle_cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // receiver: free-running stretches, random stalls and one long hold-off
  initial begin
    int pick;
    forever begin
      if (hold_req != 0) begin
        hold_req = 0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
          out_stall <= 1'b0;
          repeat ($urandom_range(1, 24)) @(posedge clk);
        end else if (pick < 85) begin
          out_stall <= 1'($urandom_range(0, 1));
          @(posedge clk);
        end else if (pick < 96) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(2, 6)) @(posedge clk);
        end else begin
          out_stall <= 1'b1;
          repeat ($urandom_range(12, 40)) @(posedge clk);
        end
      end
    end
  end

  task automatic send_item(logic [15:0] u, logic l);
    int gap;
    int r;
    in_valid <= 1'b1;
    in_item  <= {u, l};
    do @(posedge clk); while (in_stall);
    gap = 0;
    if (gap_style != 0) begin
      r = $urandom_range(0, 99);
      if (r >= 96) gap = $urandom_range(15, 40);
      else if (r >= 85) gap = $urandom_range(4, 10);
      else if (r >= 55) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // wait for all results, then for any item still in flight with no result
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.queued_units.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_config(logic [1:0] m, logic e, logic [16:0] cap);
    cfg_we    <= 1'b1;
    cfg_index <= lec_pkg::REG_MODE;
    cfg_data  <= {15'd0, m};
    @(posedge clk);
    sb.set_reg(lec_pkg::REG_MODE, {15'd0, m});
    cfg_index <= lec_pkg::REG_EXPAND;
    cfg_data  <= {16'd0, e};
    @(posedge clk);
    sb.set_reg(lec_pkg::REG_EXPAND, {16'd0, e});
    cfg_index <= lec_pkg::REG_CAPACITY;
    cfg_data  <= cap;
    @(posedge clk);
    sb.set_reg(lec_pkg::REG_CAPACITY, cap);
    cfg_we <= 1'b0;
    configs_run++;
  endtask

  task automatic run_random(int n_items);
    int sent;
    int len;
    int k;
    int r;
    logic [15:0] u;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 8);
      for (k = 0; k < len; k++) begin
        r = $urandom_range(0, 99);
        if (k == 0 && r < 10) begin
          u = lec_pkg::MARK_LE;
        end else if (k == 0 && r < 14) begin
          u = lec_pkg::MARK_BE;
        end else if (r < 16) begin
          u = lec_pkg::CH_NUL;
        end else if (r < 34) begin
          u = lec_pkg::CH_CR;
        end else if (r < 52) begin
          u = lec_pkg::CH_LF;
        end else if (r < 60) begin
          // junk high byte over a CR or LF low byte, matters in latin1 mode
          u = 16'($urandom_range(0, 65535));
          u[7:0] = (r < 56) ? lec_pkg::CH_CR[7:0] : lec_pkg::CH_LF[7:0];
        end else if (r < 80) begin
          u = 16'($urandom_range(32, 126));
        end else begin
          u = 16'($urandom_range(0, 65535));
        end
        send_item(u, k == len - 1);
        sent++;
      end
    end
  endtask

  initial begin
    int p;
    logic [1:0]  m;
    logic [16:0] cap;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // lf to crlf: leading LE mark, lone LF, CR LF pass-through
    load_config(lec_pkg::MODE_LF_CRLF, 1'b0, lec_pkg::CAPACITY_RESET);
    send_item(lec_pkg::MARK_LE, 1'b0);
    send_item(lec_pkg::CH_LF, 1'b0);
    send_item(lec_pkg::CH_CR, 1'b0);
    send_item(lec_pkg::CH_LF, 1'b0);
    send_item(16'hFFFF, 1'b1);
    // big-endian mark, then a zero unit ending the string early
    send_item(lec_pkg::MARK_BE, 1'b0);
    send_item(16'h0042, 1'b1);
    send_item(16'h0043, 1'b0);
    send_item(lec_pkg::CH_NUL, 1'b0);
    send_item(16'h0044, 1'b1);
    settle();

    // lone CR expansion, including a CR held at the end
    load_config(lec_pkg::MODE_LF_CRLF, 1'b1, lec_pkg::CAPACITY_RESET);
    send_item(lec_pkg::CH_CR, 1'b0);
    send_item(lec_pkg::CH_CR, 1'b1);
    settle();
    load_config(lec_pkg::MODE_ALIAS, 1'b0, 17'h1FFFF);
    send_item(lec_pkg::CH_LF, 1'b1);
    settle();

    // crlf to lf: mark prepended, CR runs, CR held at the end
    load_config(lec_pkg::MODE_CRLF_LF, 1'b1, lec_pkg::CAPACITY_RESET);
    send_item(lec_pkg::CH_CR, 1'b0);
    send_item(lec_pkg::CH_LF, 1'b0);
    send_item(lec_pkg::CH_CR, 1'b0);
    send_item(lec_pkg::CH_CR, 1'b0);
    send_item(lec_pkg::CH_CR, 1'b1);
    send_item(lec_pkg::MARK_BE, 1'b1);
    settle();

    // latin1: high byte ignored, LF through a junk high byte, zero low byte
    load_config(lec_pkg::MODE_LATIN1, 1'b1, lec_pkg::CAPACITY_RESET);
    send_item(lec_pkg::MARK_BE, 1'b0);
    send_item(16'hFF0A, 1'b0);
    send_item(16'h0100, 1'b0);
    send_item(16'h0001, 1'b1);
    settle();

    // zero capacity overflows on the first unit
    load_config(lec_pkg::MODE_LF_CRLF, 1'b0, 17'd0);
    send_item(16'h0041, 1'b1);
    settle();

    for (p = 0; p < 8; p++) begin
      m = (p == 7) ? 2'($urandom_range(0, 3)) : 2'(p % 4);
      case (p % 3)
        0:       cap = (p == 3) ? 17'h1FFFF : lec_pkg::CAPACITY_RESET;
        1:       cap = 17'($urandom_range(6, 40));
        default: cap = 17'($urandom_range(1, 8));
      endcase
      load_config(m, 1'($urandom_range(0, 1)), cap);
      gap_style = (p == 2 || p == 5) ? 0 : 1;
      // receiver holds off while the sender keeps offering back to back
      if (p == 2) hold_req = 1;
      run_random(30);
      settle();
    end

    $display("sent %0d source units across %0d register settings, checked %0d result units",
             sb.units_taken, configs_run, sb.results_seen);
    $display("covered all modes, lone CR expansion, LE and BE marks, zero units, overflow");
    if (sb.errors == 0 && sb.queued_units.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[sim.f]
src/lec_pkg.sv
src/lec_xlate.sv
src/utf16_line_ending_converter.sv
dv/utf16_line_ending_converter_tb.sv
